FILE: rtl/core/char_lcd_nibble_writer_core_macros.svh
// Assertion macros used by the checker file.
`ifndef CHAR_LCD_NIBBLE_WRITER_CORE_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define LCDNW_ASSERT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcd nibble writer check failed");

// Next-cycle implication, disabled while reset is low
`define LCDNW_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcd nibble writer check failed");

`endif

FILE: rtl/core/lcdnw_pkg.sv
`default_nettype none

package lcdnw_pkg;

    // Column clamp
    localparam int MAX_COLUMNS = 40;
    localparam logic [5:0] COL_LIMIT = 6'(MAX_COLUMNS - 1);

    // Request kinds
    localparam logic [2:0] KIND_TICK = 3'd0;
    localparam logic [2:0] KIND_CMD  = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_INIT = 3'd3;
    localparam logic [2:0] KIND_POS  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENABLE_PHASE = 2'd0;
    localparam logic [1:0] CFG_SLOW_SETTLE  = 2'd1;
    localparam logic [1:0] CFG_FAST_SETTLE  = 2'd2;
    localparam logic [1:0] CFG_POWERUP      = 2'd3;

    // Configuration reset values
    localparam logic [7:0]  RST_ENABLE_PHASE = 8'd4;
    localparam logic [15:0] RST_SLOW_SETTLE  = 16'd40;
    localparam logic [7:0]  RST_FAST_SETTLE  = 8'd1;
    localparam logic [15:0] RST_POWERUP      = 16'd16384;

    // LCD commands used by the sequences
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_ROW1      = 8'hC0;
    localparam logic [7:0] CMD_SHIFT_R   = 8'h14;
    localparam logic [7:0] CMD_SLOW_LIM  = 8'h04;
    localparam logic [3:0] INIT_LEN      = 4'd11;

    // Pin word: [5] enable, [4] rs, [3:0] data
    localparam logic [5:0] PIN_EN_SET = 6'h20;
    localparam logic [5:0] PIN_EN_CLR = 6'h1F;
    localparam logic [5:0] PIN_RS_CLR = 6'h0F;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_POWERUP = 6'b000010,
        PH_SETUP   = 6'b000100,
        PH_EN_HIGH = 6'b001000,
        PH_EN_LOW  = 6'b010000,
        PH_SETTLE  = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_NONE   = 2'd0,
        SEQ_SINGLE = 2'd1,
        SEQ_INIT   = 2'd2,
        SEQ_POS    = 2'd3
    } t_seq;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] byte_value;
        logic       row;
        logic [5:0] column;
    } t_in;

    typedef struct packed {
        logic [3:0] lcd_data;
        logic       lcd_rs;
        logic       lcd_en;
        logic       busy_res;
        logic       rejected;
    } t_out;

    typedef struct packed {
        logic [7:0]  enable_phase_ticks;
        logic [15:0] slow_settle_ticks;
        logic [7:0]  fast_settle_ticks;
        logic [15:0] powerup_ticks;
    } t_cfg;

    // Init command ROM
    function automatic logic [7:0] init_cmd(input logic [3:0] step);
        logic [7:0] c;
        case (step)
            4'd0:    c = 8'h02;
            4'd1:    c = 8'h28;
            4'd2:    c = 8'h0E;
            4'd3:    c = 8'h01;
            4'd4:    c = 8'h80;
            4'd5:    c = 8'h06;
            4'd6:    c = 8'h01;
            4'd7:    c = 8'h0F;
            4'd8:    c = 8'h01;
            4'd9:    c = 8'h80;
            4'd10:   c = 8'h01;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/char_lcd_nibble_writer_core.sv
// Channel   Direction  Handshake                   Word
// in        input      i_in_valid / o_in_ready     i_in_data   (kind, byte, row, column)
// out       output     o_out_valid / i_out_ready   o_out_data  (pins, busy, rejected)
// cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One word per clock unless stalled; one result per accepted word, valid next cycle.
// The sequencer state and the output register are the only stages on the path.
// A word is taken while the result register is empty or being read in the same cycle.
// Config writes are always taken.
// Reset (i_rst_n low, synchronous) puts the sequencer in idle with all pins low.
`default_nettype none

module char_lcd_nibble_writer_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output wire logic          o_in_ready,
    input  wire lcdnw_pkg::t_in i_in_data,
    output wire logic          o_out_valid,
    input  wire logic          i_out_ready,
    output lcdnw_pkg::t_out    o_out_data,
    input  wire logic          i_cfg_valid,
    output wire logic          o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data
);
    import lcdnw_pkg::*;

    t_cfg cfg;
    t_out result;
    logic can_load;
    logic accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = can_load;
    assign accept      = i_in_valid && can_load;

    lcdnw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_data),
        .o_cfg   (cfg)
    );

    lcdnw_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    lcdnw_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_can_load  (can_load)
    );

endmodule

`default_nettype wire

FILE: rtl/core/lcdnw_cfg_regs.sv
`default_nettype none

module lcdnw_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire logic [1:0]    i_index,
    input  wire logic [15:0]   i_wdata,
    output lcdnw_pkg::t_cfg    o_cfg
);
    import lcdnw_pkg::*;

    t_cfg r_cfg;

    // Register file, written one word at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_phase_ticks <= RST_ENABLE_PHASE;
            r_cfg.slow_settle_ticks  <= RST_SLOW_SETTLE;
            r_cfg.fast_settle_ticks  <= RST_FAST_SETTLE;
            r_cfg.powerup_ticks      <= RST_POWERUP;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_ENABLE_PHASE: r_cfg.enable_phase_ticks <= i_wdata[7:0];
                CFG_SLOW_SETTLE:  r_cfg.slow_settle_ticks  <= i_wdata;
                CFG_FAST_SETTLE:  r_cfg.fast_settle_ticks  <= i_wdata[7:0];
                CFG_POWERUP:      r_cfg.powerup_ticks      <= i_wdata;
                default:          ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/lcdnw_seq.sv
`default_nettype none

module lcdnw_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire lcdnw_pkg::t_in  i_item,
    input  wire lcdnw_pkg::t_cfg i_cfg,
    output lcdnw_pkg::t_out    o_result
);
    import lcdnw_pkg::*;

    t_phase      r_phase, n_phase;
    t_seq        r_seq, n_seq;
    logic [15:0] r_wait, n_wait;
    logic [7:0]  r_shift, n_shift;
    logic        r_sel, n_sel;
    logic        r_lnn, n_lnn;
    logic [3:0]  r_init, n_init;
    logic [5:0]  r_shifts, n_shifts;
    logic        r_row, n_row;
    logic [5:0]  r_pin, n_pin;

    logic        busy;
    logic        rejected;
    logic        next_go;
    logic        start_go;
    logic        setup_go;
    logic [7:0]  start_byte;
    logic        start_rs;
    logic [15:0] wait_dec;
    logic [15:0] phase_len;
    logic [15:0] settle_len;

    assign busy = (r_phase != PH_IDLE);

    // Enable phase length, zero taken as one
    assign phase_len = (i_cfg.enable_phase_ticks == 8'd0) ? 16'd1
                                                          : {8'd0, i_cfg.enable_phase_ticks};

    // Slow settle only after commands below four
    assign settle_len = (!r_sel && (r_shift < CMD_SLOW_LIM)) ? i_cfg.slow_settle_ticks
                                                              : {8'd0, i_cfg.fast_settle_ticks};

    // Next-state logic for one word
    always_comb begin
        n_phase    = r_phase;
        n_seq      = r_seq;
        n_wait     = r_wait;
        n_shift    = r_shift;
        n_sel      = r_sel;
        n_lnn      = r_lnn;
        n_init     = r_init;
        n_shifts   = r_shifts;
        n_row      = r_row;
        n_pin      = r_pin;
        rejected   = 1'b0;
        next_go    = 1'b0;
        start_go   = 1'b0;
        setup_go   = 1'b0;
        start_byte = 8'd0;
        start_rs   = 1'b0;
        wait_dec   = 16'd0;

        if (i_accept) begin
            unique case (i_item.kind) inside
                KIND_TICK: begin
                    if (busy) begin
                        wait_dec = (r_wait != 16'd0) ? (r_wait - 16'd1) : 16'd0;
                        n_wait   = wait_dec;
                        if (wait_dec == 16'd0) begin
                            unique case (r_phase)
                                PH_POWERUP: next_go = 1'b1;
                                PH_SETUP: begin
                                    n_pin   = r_pin | PIN_EN_SET;
                                    n_phase = PH_EN_HIGH;
                                    n_wait  = phase_len;
                                end
                                PH_EN_HIGH: begin
                                    n_pin   = r_pin & PIN_EN_CLR;
                                    n_phase = PH_EN_LOW;
                                    n_wait  = phase_len;
                                end
                                PH_EN_LOW: begin
                                    n_pin = r_pin & PIN_RS_CLR;
                                    if (!r_lnn) begin
                                        n_lnn    = 1'b1;
                                        setup_go = 1'b1;
                                    end else begin
                                        n_phase = PH_SETTLE;
                                        n_wait  = settle_len;
                                        if (settle_len == 16'd0) begin
                                            next_go = 1'b1;
                                        end
                                    end
                                end
                                PH_SETTLE: next_go = 1'b1;
                                default: begin
                                    n_phase = PH_IDLE;
                                    n_wait  = 16'd0;
                                    n_seq   = SEQ_NONE;
                                end
                            endcase
                        end
                    end
                end
                KIND_CMD, KIND_DATA: begin
                    if (busy) begin
                        rejected = 1'b1;
                    end else begin
                        n_seq      = SEQ_SINGLE;
                        start_go   = 1'b1;
                        start_byte = i_item.byte_value;
                        start_rs   = (i_item.kind == KIND_DATA);
                    end
                end
                KIND_INIT: begin
                    if (busy) begin
                        rejected = 1'b1;
                    end else begin
                        n_seq   = SEQ_INIT;
                        n_init  = 4'd0;
                        n_phase = PH_POWERUP;
                        n_wait  = i_cfg.powerup_ticks;
                        if (i_cfg.powerup_ticks == 16'd0) begin
                            next_go = 1'b1;
                        end
                    end
                end
                KIND_POS: begin
                    if (busy) begin
                        rejected = 1'b1;
                    end else begin
                        n_seq      = SEQ_POS;
                        n_row      = i_item.row;
                        n_shifts   = (i_item.column > COL_LIMIT) ? COL_LIMIT : i_item.column;
                        start_go   = 1'b1;
                        start_byte = CMD_HOME;
                    end
                end
                default: ;
            endcase
        end

        // Pick the next byte of the running sequence, or go idle
        if (next_go) begin
            if ((n_seq == SEQ_INIT) && (n_init < INIT_LEN)) begin
                start_go   = 1'b1;
                start_byte = init_cmd(n_init);
                n_init     = n_init + 4'd1;
            end else if ((n_seq == SEQ_POS) && n_row) begin
                n_row      = 1'b0;
                start_go   = 1'b1;
                start_byte = CMD_ROW1;
            end else if ((n_seq == SEQ_POS) && (n_shifts != 6'd0)) begin
                n_shifts   = n_shifts - 6'd1;
                start_go   = 1'b1;
                start_byte = CMD_SHIFT_R;
            end else begin
                n_phase = PH_IDLE;
                n_wait  = 16'd0;
                n_init  = 4'd0;
                n_seq   = SEQ_NONE;
            end
        end

        // Load a new byte, upper nibble first
        if (start_go) begin
            n_shift  = start_byte;
            n_sel    = start_rs;
            n_lnn    = 1'b0;
            setup_go = 1'b1;
        end

        // Drive the nibble with enable low
        if (setup_go) begin
            n_pin   = {1'b0, n_sel, (n_lnn ? n_shift[3:0] : n_shift[7:4])};
            n_phase = PH_SETUP;
            n_wait  = phase_len;
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_seq    <= SEQ_NONE;
            r_wait   <= 16'd0;
            r_shift  <= 8'd0;
            r_sel    <= 1'b0;
            r_lnn    <= 1'b0;
            r_init   <= 4'd0;
            r_shifts <= 6'd0;
            r_row    <= 1'b0;
            r_pin    <= 6'd0;
        end else begin
            r_phase  <= n_phase;
            r_seq    <= n_seq;
            r_wait   <= n_wait;
            r_shift  <= n_shift;
            r_sel    <= n_sel;
            r_lnn    <= n_lnn;
            r_init   <= n_init;
            r_shifts <= n_shifts;
            r_row    <= n_row;
            r_pin    <= n_pin;
        end
    end

    // Result word after this step's update
    assign o_result = '{
        lcd_data: n_pin[3:0],
        lcd_rs:   n_pin[4],
        lcd_en:   n_pin[5],
        busy_res: (n_phase != PH_IDLE),
        rejected: rejected
    };

endmodule

`default_nettype wire

FILE: rtl/core/lcdnw_out_reg.sv
`default_nettype none

module lcdnw_out_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire lcdnw_pkg::t_out i_result,
    input  wire logic          i_out_ready,
    output wire logic          o_out_valid,
    output lcdnw_pkg::t_out    o_out_data,
    output wire logic          o_can_load
);
    import lcdnw_pkg::*;

    logic r_valid;
    t_out r_data;

    // Free, or emptied this cycle
    assign o_can_load = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

`default_nettype wire

FILE: rtl/core/lcdnw_checker.sv
`default_nettype none

`include "char_lcd_nibble_writer_core_macros.svh"

module lcdnw_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          o_in_ready,
    input  wire logic          o_out_valid,
    input  wire logic          i_out_ready,
    input  wire lcdnw_pkg::t_out o_out_data
);
    import lcdnw_pkg::*;

    // A dropped request never ends a sequence
    `LCDNW_ASSERT(a_rej_busy, i_clk, i_rst_n, o_out_valid && o_out_data.rejected, o_out_data.busy_res)

    // Enable is only ever high inside a transfer
    `LCDNW_ASSERT(a_en_busy, i_clk, i_rst_n, o_out_valid && o_out_data.lcd_en, o_out_data.busy_res)

    // Empty result register never stalls the input
    `LCDNW_ASSERT(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // Accepted word shows up in the next cycle
    `LCDNW_ASSERT_NEXT(a_accept_out, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // Stalled result holds
    `LCDNW_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind char_lcd_nibble_writer_core lcdnw_checker u_lcdnw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire

FILE: tb/char_lcd_nibble_writer_core_tb.sv
`timescale 1ns / 100ps

module char_lcd_nibble_writer_core_tb;
    import lcdnw_pkg::*;

    localparam int KIND_MAX        = 7;
    localparam int GAP_MAX         = 4;
    localparam int RANDOM_PHASES   = 4;
    localparam int WORDS_PER_PHASE = 40;
    localparam int DRAIN_CYCLES    = 4;

    // Tracks the sequencer and predicts the pin/status word for each request word
    class pin_scoreboard;
        localparam logic [87:0] INIT_STREAM = 88'h02_28_0E_01_80_06_01_0F_01_80_01;
        localparam int PRINT_CAP = 100;

        t_cfg        regs;
        t_phase      phase;
        t_seq        seq;
        logic [15:0] wait_count;
        logic [7:0]  shift_byte;
        logic        select_data;
        logic        low_next;
        logic [3:0]  init_step;
        logic [5:0]  shifts_left;
        logic        row_pending;
        logic [5:0]  pins;          // [5] en, [4] rs, [3:0] data
        t_out        pins_due[$];
        int          err_count;

        function new();
            regs.enable_phase_ticks = RST_ENABLE_PHASE;
            regs.slow_settle_ticks  = RST_SLOW_SETTLE;
            regs.fast_settle_ticks  = RST_FAST_SETTLE;
            regs.powerup_ticks      = RST_POWERUP;
            phase       = PH_IDLE;
            seq         = SEQ_NONE;
            wait_count  = '0;
            shift_byte  = '0;
            select_data = 1'b0;
            low_next    = 1'b0;
            init_step   = '0;
            shifts_left = '0;
            row_pending = 1'b0;
            pins        = '0;
            err_count   = 0;
        endfunction

        task report(string msg);
            err_count++;
            if (err_count <= PRINT_CAP) begin
                $display("mismatch: %s", msg);
            end
        endtask

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_ENABLE_PHASE: regs.enable_phase_ticks = val[7:0];
                CFG_SLOW_SETTLE:  regs.slow_settle_ticks  = val;
                CFG_FAST_SETTLE:  regs.fast_settle_ticks  = val[7:0];
                CFG_POWERUP:      regs.powerup_ticks      = val;
                default: ;
            endcase
        endfunction

        // A zero enable time counts as one tick
        function logic [15:0] phase_ticks();
            return (regs.enable_phase_ticks == 0) ? 16'd1 : 16'(regs.enable_phase_ticks);
        endfunction

        function void load_nibble();
            pins = {1'b0, select_data, low_next ? shift_byte[3:0] : shift_byte[7:4]};
            phase = PH_SETUP;
            wait_count = phase_ticks();
        endfunction

        function void begin_byte(logic [7:0] b, logic rs);
            shift_byte  = b;
            select_data = rs;
            low_next    = 1'b0;
            load_nibble();
        endfunction

        // Pick the next byte of the running sequence, or go idle
        function void next_byte();
            if (seq == SEQ_INIT && init_step < INIT_LEN) begin
                begin_byte(INIT_STREAM[87 - 8 * init_step -: 8], 1'b0);
                init_step++;
            end else if (seq == SEQ_POS && row_pending) begin
                row_pending = 1'b0;
                begin_byte(CMD_ROW1, 1'b0);
            end else if (seq == SEQ_POS && shifts_left != 0) begin
                shifts_left--;
                begin_byte(CMD_SHIFT_R, 1'b0);
            end else begin
                phase      = PH_IDLE;
                wait_count = '0;
                init_step  = '0;
                seq        = SEQ_NONE;
            end
        endfunction

        // Leave the current phase once its count has run out
        function void step_phase();
            case (phase)
                PH_POWERUP, PH_SETTLE: next_byte();
                PH_SETUP: begin
                    pins[5]    = 1'b1;
                    phase      = PH_EN_HIGH;
                    wait_count = phase_ticks();
                end
                PH_EN_HIGH: begin
                    pins[5]    = 1'b0;
                    phase      = PH_EN_LOW;
                    wait_count = phase_ticks();
                end
                PH_EN_LOW: begin
                    pins[5:4] = 2'b00;
                    if (!low_next) begin
                        low_next = 1'b1;
                        load_nibble();
                    end else begin
                        phase = PH_SETTLE;
                        wait_count = (!select_data && shift_byte < CMD_SLOW_LIM) ?
                                     regs.slow_settle_ticks : 16'(regs.fast_settle_ticks);
                        if (wait_count == 0) begin
                            next_byte();
                        end
                    end
                end
                default: begin
                    phase      = PH_IDLE;
                    wait_count = '0;
                    seq        = SEQ_NONE;
                end
            endcase
        endfunction

        function void note_request(t_in w);
            t_out want;
            logic busy_now;
            logic rej;
            busy_now = (phase != PH_IDLE);
            rej = 1'b0;
            case (w.kind)
                KIND_TICK: begin
                    if (busy_now) begin
                        if (wait_count != 0) begin
                            wait_count--;
                        end
                        if (wait_count == 0) begin
                            step_phase();
                        end
                    end
                end
                KIND_CMD, KIND_DATA: begin
                    if (busy_now) begin
                        rej = 1'b1;
                    end else begin
                        seq = SEQ_SINGLE;
                        begin_byte(w.byte_value, w.kind == KIND_DATA);
                    end
                end
                KIND_INIT: begin
                    if (busy_now) begin
                        rej = 1'b1;
                    end else begin
                        seq        = SEQ_INIT;
                        init_step  = '0;
                        phase      = PH_POWERUP;
                        wait_count = regs.powerup_ticks;
                        if (wait_count == 0) begin
                            next_byte();
                        end
                    end
                end
                KIND_POS: begin
                    if (busy_now) begin
                        rej = 1'b1;
                    end else begin
                        seq         = SEQ_POS;
                        row_pending = w.row;
                        shifts_left = (w.column > COL_LIMIT) ? COL_LIMIT : w.column;
                        begin_byte(CMD_HOME, 1'b0);
                    end
                end
                default: ;  // unknown kinds are ignored
            endcase
            want.lcd_data = pins[3:0];
            want.lcd_rs   = pins[4];
            want.lcd_en   = pins[5];
            want.busy_res = (phase != PH_IDLE);
            want.rejected = rej;
            pins_due.push_back(want);
        endfunction

        task check_result(t_out got);
            t_out want;
            if (pins_due.size() == 0) begin
                report($sformatf("result word %h with nothing expected", got));
                return;
            end
            want = pins_due.pop_front();
            if (got.lcd_data !== want.lcd_data)
                report($sformatf("lcd_data %h, expected %h", got.lcd_data, want.lcd_data));
            if (got.lcd_rs !== want.lcd_rs)
                report($sformatf("lcd_rs %b, expected %b", got.lcd_rs, want.lcd_rs));
            if (got.lcd_en !== want.lcd_en)
                report($sformatf("lcd_en %b, expected %b", got.lcd_en, want.lcd_en));
            if (got.busy_res !== want.busy_res)
                report($sformatf("busy_res %b, expected %b", got.busy_res, want.busy_res));
            if (got.rejected !== want.rejected)
                report($sformatf("rejected %b, expected %b", got.rejected, want.rejected));
        endtask

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return pins_due.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in         in_data   = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    wire         in_ready;
    wire         out_valid;
    wire         cfg_ready;
    t_out        out_data;

    bit tx_idle_en  = 1'b0;
    bit rx_stall_en = 1'b0;

    pin_scoreboard sb;

    char_lcd_nibble_writer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Send one request word; valid stays high across back-to-back words
    task automatic send_word(input t_in w);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(w);
    endtask

    function automatic t_in make_word(logic [2:0] kind, logic [7:0] b, logic r, logic [5:0] c);
        t_in w;
        w.kind       = kind;
        w.byte_value = b;
        w.row        = r;
        w.column     = c;
        return w;
    endfunction

    // Mostly ticks while a sequence runs, mostly requests while idle
    function automatic t_in draw_word(input bit busy_now);
        t_in w;
        int roll;
        roll = $urandom_range(0, 99);
        w.byte_value = 8'($urandom);
        w.row        = 1'($urandom);
        w.column     = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
        if (roll < (busy_now ? 92 : 15)) begin
            w.kind = KIND_TICK;
        end else if (roll < (busy_now ? 98 : 90)) begin
            w.kind = 3'($urandom_range(KIND_CMD, KIND_POS));
        end else begin
            w.kind = 3'($urandom_range(int'(KIND_POS) + 1, KIND_MAX));
        end
        return w;
    endfunction

    // Write all four registers; 8-bit registers get random upper data bits
    task automatic program_regs(input logic [7:0] en_t, input logic [15:0] slow_t,
                                input logic [7:0] fast_t, input logic [15:0] pup_t);
        logic [15:0] vals [0:3];
        vals[CFG_ENABLE_PHASE] = {8'($urandom), en_t};
        vals[CFG_SLOW_SETTLE]  = slow_t;
        vals[CFG_FAST_SETTLE]  = {8'($urandom), fast_t};
        vals[CFG_POWERUP]      = pup_t;
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.write_reg(2'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Tick the sequencer back to idle at full rate and let all results drain
    task automatic settle_block();
        t_in tick_word;
        tick_word = make_word(KIND_TICK, 8'h00, 1'b0, 6'd0);
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        while (sb.busy()) send_word(tick_word);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random back-pressure per word
    initial begin : result_sink
        int stall;
        @(posedge rst_n);
        forever begin
            stall = rx_stall_en ? $urandom_range(0, GAP_MAX) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_result(out_data);
        end
    end

    initial begin : stimulus
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: slow settle command, requests while busy, unknown kind
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        send_word(make_word(KIND_CMD, 8'h03, 1'b0, 6'd0));
        send_word(make_word(KIND_POS, 8'h00, 1'b1, 6'd5));
        send_word(make_word(3'(KIND_MAX), 8'hFF, 1'b1, 6'h3F));
        send_word(make_word(KIND_TICK, 8'h00, 1'b0, 6'd0));
        settle_block();
        send_word(make_word(KIND_DATA, 8'h00, 1'b0, 6'd0));
        settle_block();

        // Shortest timing, zero settle and zero power-up
        program_regs(8'd1, 16'd0, 8'd0, 16'd0);
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
        send_word(make_word(KIND_INIT, 8'h00, 1'b0, 6'd0));
        send_word(make_word(KIND_CMD, 8'hFF, 1'b0, 6'd0));
        send_word(make_word(KIND_INIT, 8'h00, 1'b0, 6'd0));
        settle_block();
        send_word(make_word(KIND_POS, 8'h00, 1'b1, 6'h3F));   // column clamps
        settle_block();
        send_word(make_word(KIND_DATA, 8'hFF, 1'b1, 6'd0));
        settle_block();
        send_word(make_word(KIND_CMD, 8'h00, 1'b0, 6'd0));
        settle_block();
        send_word(make_word(3'(int'(KIND_POS) + 1), 8'h55, 1'b0, 6'd0));
        send_word(make_word(3'(int'(KIND_POS) + 2), 8'hAA, 1'b1, 6'h2A));
        send_word(make_word(KIND_TICK, 8'hFF, 1'b1, 6'h3F));
        settle_block();

        // Enable time of zero behaves as one tick
        program_regs(8'd0, 16'd2, 8'd0, 16'd3);
        send_word(make_word(KIND_POS, 8'h00, 1'b0, 6'd0));
        settle_block();
        send_word(make_word(KIND_INIT, 8'h00, 1'b0, 6'd0));
        settle_block();
        send_word(make_word(KIND_DATA, 8'h5A, 1'b0, 6'd0));
        settle_block();

        // Slow settle that needs the upper counter byte
        program_regs(8'd2, 16'h0100, 8'd3, 16'd0);
        send_word(make_word(KIND_CMD, 8'h00, 1'b0, 6'd0));
        send_word(make_word(KIND_DATA, 8'h41, 1'b1, 6'd0));
        settle_block();
        send_word(make_word(KIND_CMD, 8'h04, 1'b0, 6'd0));
        settle_block();

        // Power-up wait that needs the upper counter byte
        program_regs(8'd1, 16'd0, 8'd0, 16'h0100);
        send_word(make_word(KIND_INIT, 8'h00, 1'b0, 6'd0));
        settle_block();

        // Random phases with short timing so sequences complete often
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            program_regs(8'($urandom_range(0, 2)), 16'($urandom_range(0, 12)),
                         8'($urandom_range(0, 3)), 16'($urandom_range(0, 20)));
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            repeat (WORDS_PER_PHASE) send_word(draw_word(sb.busy()));
            settle_block();
        end

        if (sb.err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
